[src/bms_pkg.sv]
// ----------------------------------------------------------------------------
// bms_pkg: shared types and constants
// Widths, limits and the transaction structs used by the mean/std unit.
// ----------------------------------------------------------------------------
package bms_pkg;

	localparam int CoordWidth   = 24;
	localparam int MaxParticles = 65536;
	localparam int NCoord       = 4;
	localparam int CountWidth   = $clog2(MaxParticles + 1);
	localparam int SumWidth     = 40;
	localparam int SqWidth      = 64;
	localparam int StdWidth     = 23;
	localparam int RootWidth    = 32;
	localparam int QueueDepth   = 2;

	typedef logic signed [CoordWidth-1:0] coord_t;

	typedef struct packed {
		coord_t pos_x;
		coord_t angle_x;
		coord_t energy_dev;
		coord_t long_pos;
		logic   full_stats;
		logic   last;
	} in_item_t;

	typedef struct packed {
		coord_t              mean_x;
		coord_t              mean_angle;
		coord_t              mean_energy;
		coord_t              mean_long;
		logic [StdWidth-1:0] std_x;
		logic [StdWidth-1:0] std_angle;
		logic [StdWidth-1:0] std_energy;
		logic [StdWidth-1:0] std_long;
		logic                stats_full;
	} out_item_t;

	// Finished bunch totals handed from front to back.
	typedef struct packed {
		logic [NCoord-1:0][SumWidth-1:0] sums;
		logic [NCoord-1:0][SqWidth-1:0]  sqs;
		logic [CountWidth-1:0]           count;
		logic                            full;
	} bunch_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MEAN,
		ST_MSQ,
		ST_ROOT,
		ST_OUT
	} back_state_t;

endpackage

[src/bms_if.sv]
// ----------------------------------------------------------------------------
// bms_in_if / bms_out_if: valid/ready channels
// Input particle channel and result channel.
// ----------------------------------------------------------------------------
interface bms_in_if;
	logic              valid;
	logic              ready;
	bms_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bms_out_if;
	logic               valid;
	logic               ready;
	bms_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[src/bms_front.sv]
// ----------------------------------------------------------------------------
// bms_front: accumulator front end
// Squares and sums coordinates; pushes bunch totals on the last particle.
// ----------------------------------------------------------------------------
module bms_front (
	input  logic                clk,
	input  logic                arst_n,
	bms_in_if.sink              in_ch,
	output logic                push,
	output bms_pkg::bunch_t     push_data,
	input  logic                q_full
);
	localparam int W  = bms_pkg::CoordWidth;
	localparam int NC = bms_pkg::NCoord;

	logic                            v_s1, last_s1, full_s1;
	logic [NC-1:0][2*W-1:0]          sq_s1;
	logic [NC-1:0][W-1:0]            c_s1;
	logic [NC-1:0][bms_pkg::SumWidth-1:0] sum_q;
	logic [NC-1:0][bms_pkg::SqWidth-1:0]  sq_q;
	logic [bms_pkg::CountWidth-1:0]  cnt_q;
	logic                            acc_ok;
	logic                            take;
	logic [NC-1:0][W-1:0]            cin;

	// One bunch end may be in stage 1; stall input while it is there or the queue is full.
	assign in_ch.ready = !q_full && !(v_s1 && last_s1);
	assign take = in_ch.valid && in_ch.ready;
	assign cin[0] = in_ch.data.pos_x;
	assign cin[1] = in_ch.data.angle_x;
	assign cin[2] = in_ch.data.energy_dev;
	assign cin[3] = in_ch.data.long_pos;
	assign acc_ok = cnt_q < bms_pkg::CountWidth'(bms_pkg::MaxParticles);

	always_ff @(posedge clk) begin
		for (int i = 0; i < NC; i++) begin
			c_s1[i]  <= cin[i];
			sq_s1[i] <= $signed(cin[i]) * $signed(cin[i]);
		end
		last_s1 <= in_ch.data.last;
		full_s1 <= in_ch.data.full_stats;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			sum_q <= '0;
			sq_q  <= '0;
			cnt_q <= '0;
		end else begin
			v_s1 <= take;
			if (v_s1) begin
				if (last_s1) begin
					sum_q <= '0;
					sq_q  <= '0;
					cnt_q <= '0;
				end else if (acc_ok) begin
					for (int i = 0; i < NC; i++) begin
						sum_q[i] <= sum_q[i] + bms_pkg::SumWidth'($signed(c_s1[i]));
						sq_q[i]  <= sq_q[i] + bms_pkg::SqWidth'(sq_s1[i]);
					end
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_comb begin
		push = v_s1 && last_s1;
		push_data.full = full_s1;
		for (int i = 0; i < NC; i++) begin
			push_data.sums[i] = acc_ok ? sum_q[i] + bms_pkg::SumWidth'($signed(c_s1[i]))
			                           : sum_q[i];
			push_data.sqs[i]  = acc_ok ? sq_q[i] + bms_pkg::SqWidth'(sq_s1[i]) : sq_q[i];
		end
		push_data.count = acc_ok ? cnt_q + 1'b1 : cnt_q;
	end
endmodule

[src/bms_queue.sv]
// ----------------------------------------------------------------------------
// bms_queue: bunch totals FIFO
// Short register FIFO between accumulator and divider.
// ----------------------------------------------------------------------------
module bms_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bms_pkg::bunch_t push_data,
	output logic            full,
	output logic            not_empty,
	input  logic            pop,
	output bms_pkg::bunch_t pop_data
);
	localparam int D  = bms_pkg::QueueDepth;
	localparam int AW = $clog2(D);

	bms_pkg::bunch_t    mem_q [D];
	logic [AW-1:0]      wp_q, rp_q;
	logic [AW:0]        n_q;

	assign full      = n_q == (AW+1)'(D);
	assign not_empty = n_q != '0;
	assign pop_data  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			n_q  <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(D-1)) ? '0 : wp_q + 1'b1;
			if (pop)  rp_q <= (rp_q == AW'(D-1)) ? '0 : rp_q + 1'b1;
			n_q <= n_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

[src/bms_back.sv]
// ----------------------------------------------------------------------------
// bms_back: divide and root back end
// Serial floor divides and integer square roots, one coordinate at a time.
// ----------------------------------------------------------------------------
module bms_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_ne,
	input  bms_pkg::bunch_t q_data,
	output logic            q_pop,
	bms_out_if.source       out_ch
);
	localparam int NC = bms_pkg::NCoord;
	localparam int SW = bms_pkg::SumWidth;
	localparam int QW = bms_pkg::SqWidth;
	localparam int CW = bms_pkg::CountWidth;
	localparam int RW = bms_pkg::RootWidth;
	localparam int W  = bms_pkg::CoordWidth;

	bms_pkg::back_state_t st_q, st_d;
	bms_pkg::bunch_t      b_q;
	logic [1:0]           ci_q;
	logic [6:0]           step_q;
	logic [QW-1:0]        num_q;    // shifting dividend / quotient
	logic [CW:0]          rem_q;
	logic                 neg_q;
	logic signed [W:0]    mean_q [NC];
	logic [QW-1:0]        rad_q;
	logic [RW-1:0]        root_q;
	logic [RW+1:0]        rrem_q;
	logic [bms_pkg::StdWidth-1:0] sd_q [NC];
	logic                 ovalid_q;
	bms_pkg::out_item_t   odata_q;

	logic [CW:0]          trial;
	logic [CW:0]          rsh;
	logic [RW+1:0]        rtrial;
	logic [RW+1:0]        rrsh;
	logic signed [W:0]    mfix;
	logic signed [2*W+1:0] msqr;
	logic signed [QW:0]   radf;

	// Restoring divide, one bit a cycle.
	assign rsh   = {rem_q[CW-1:0], num_q[QW-1]};
	assign trial = rsh - (CW+1)'(b_q.count);
	// Restoring square root, two radicand bits a cycle.
	assign rrsh   = {rrem_q[RW-1:0], rad_q[QW-1:QW-2]};
	assign rtrial = rrsh - {root_q, 2'b01};

	always_comb begin
		// Floor correction on the magnitude quotient of a negative sum.
		if (neg_q)
			mfix = $signed(-(W+1)'(num_q) - (W+1)'(rem_q != '0));
		else
			mfix = $signed((W+1)'(num_q));
	end
	assign msqr = mean_q[ci_q] * mean_q[ci_q];
	assign radf = $signed({1'b0, num_q}) - (QW+1)'(msqr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= bms_pkg::ST_IDLE;
		else         st_q <= st_d;
	end

	always_comb begin
		st_d  = st_q;
		q_pop = 1'b0;
		case (st_q)
			bms_pkg::ST_IDLE: if (q_ne && !ovalid_q) st_d = bms_pkg::ST_MEAN;
			bms_pkg::ST_MEAN: if (step_q == 7'(SW)) begin
				if (!b_q.full) st_d = bms_pkg::ST_OUT;
				else           st_d = bms_pkg::ST_MSQ;
			end
			bms_pkg::ST_MSQ:  if (step_q == 7'(QW)) st_d = bms_pkg::ST_ROOT;
			bms_pkg::ST_ROOT: if (step_q == 7'(RW)) begin
				if (ci_q == 2'(NC-1)) st_d = bms_pkg::ST_OUT;
				else                  st_d = bms_pkg::ST_MEAN;
			end
			bms_pkg::ST_OUT: begin
				st_d  = bms_pkg::ST_IDLE;
				q_pop = 1'b1;
			end
			default: st_d = bms_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (st_q)
			bms_pkg::ST_IDLE: begin
				b_q    <= q_data;
				ci_q   <= '0;
				step_q <= '0;
				rem_q  <= '0;
				neg_q  <= q_data.sums[0][SW-1];
				num_q  <= QW'(q_data.sums[0][SW-1] ? -q_data.sums[0] : q_data.sums[0])
				          << (QW - SW);
				for (int i = 0; i < NC; i++) begin
					mean_q[i] <= '0;
					sd_q[i]   <= '0;
				end
			end
			bms_pkg::ST_MEAN: begin
				if (step_q == 7'(SW)) begin
					mean_q[ci_q] <= mfix;
					step_q <= '0;
					rem_q  <= '0;
					num_q  <= b_q.sqs[ci_q];
				end else begin
					step_q <= step_q + 1'b1;
					rem_q  <= trial[CW] ? rsh : trial;
					num_q  <= {num_q[QW-2:0], ~trial[CW]};
				end
			end
			bms_pkg::ST_MSQ: begin
				if (step_q == 7'(QW)) begin
					step_q <= '0;
					rad_q  <= radf[QW] ? '0 : radf[QW-1:0];
					root_q <= '0;
					rrem_q <= '0;
				end else begin
					step_q <= step_q + 1'b1;
					rem_q  <= trial[CW] ? rsh : trial;
					num_q  <= {num_q[QW-2:0], ~trial[CW]};
				end
			end
			bms_pkg::ST_ROOT: begin
				if (step_q == 7'(RW)) begin
					sd_q[ci_q] <= (root_q > RW'({bms_pkg::StdWidth{1'b1}})) ?
					              '1 : root_q[bms_pkg::StdWidth-1:0];
					ci_q   <= ci_q + 1'b1;
					step_q <= '0;
					rem_q  <= '0;
					neg_q  <= b_q.sums[2'(ci_q + 1'b1)][SW-1];
					num_q  <= QW'(b_q.sums[2'(ci_q + 1'b1)][SW-1] ?
					          -b_q.sums[2'(ci_q + 1'b1)] : b_q.sums[2'(ci_q + 1'b1)])
					          << (QW - SW);
				end else begin
					step_q <= step_q + 1'b1;
					rad_q  <= {rad_q[QW-3:0], 2'b00};
					rrem_q <= rtrial[RW+1] ? rrsh : rtrial;
					root_q <= {root_q[RW-2:0], ~rtrial[RW+1]};
				end
			end
			default: ;
		endcase
	end

	// Output register: fill on completion, drop when the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovalid_q <= 1'b0;
		else if (st_q == bms_pkg::ST_OUT) ovalid_q <= 1'b1;
		else if (out_ch.ready) ovalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (st_q == bms_pkg::ST_OUT) begin
			odata_q.mean_x      <= mean_q[0][W-1:0];
			odata_q.mean_angle  <= mean_q[1][W-1:0];
			odata_q.mean_energy <= mean_q[2][W-1:0];
			odata_q.mean_long   <= mean_q[3][W-1:0];
			odata_q.std_x       <= sd_q[0];
			odata_q.std_angle   <= sd_q[1];
			odata_q.std_energy  <= sd_q[2];
			odata_q.std_long    <= sd_q[3];
			odata_q.stats_full  <= b_q.full;
		end
	end

	assign out_ch.valid = ovalid_q;
	assign out_ch.data  = odata_q;
endmodule

[src/bunch_mean_and_std_unit.sv]
// ----------------------------------------------------------------------------
// bunch_mean_and_std_unit: bunch mean and standard deviation
// Streams particles and reports per-coordinate floor mean and deviation.
// ----------------------------------------------------------------------------
// Particles are taken one per cycle; the accumulator squares each coordinate
// in a register stage and adds into the 40-bit sums and 64-bit square sums.
// On the transaction marked last the bunch totals are pushed into a two-entry
// queue and the sums clear. The back end then works each bunch through a
// bit-serial restoring divider and root: it loads the bunch, divides out the
// first mean, and with full statistics then works, per coordinate, the mean,
// the mean of squares and the root before it loads the output register.
// Input stalls in the cycle after every transaction marked last, and while
// the queue is full. A mean is floor(sum/n); a deviation is
// floor(sqrt(floor(sumsq/n) - mean^2)), with a negative radicand clamped to
// zero and the root saturated at 2^23-1.
// Particles beyond 65536 in one bunch are ignored, a last one still ends it.
module bunch_mean_and_std_unit (
	input  logic      clk,
	input  logic      arst_n,
	bms_in_if.sink    in_ch,
	bms_out_if.source out_ch
);
	logic            push, q_full, q_ne, q_pop;
	bms_pkg::bunch_t push_data, pop_data;

	bms_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.push(push), .push_data(push_data), .q_full(q_full)
	);

	bms_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data),
		.full(q_full), .not_empty(q_ne), .pop(q_pop), .pop_data(pop_data)
	);

	bms_back u_back (
		.clk(clk), .arst_n(arst_n), .q_ne(q_ne), .q_data(pop_data),
		.q_pop(q_pop), .out_ch(out_ch)
	);
endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb: bench for bunch_mean_and_std_unit
// Drives bunches of particles, predicts the floor mean and deviation of each
// bunch and checks every result transaction against the prediction.
// ----------------------------------------------------------------------------
module tb;

	logic clk;
	logic arst_n;

	bms_in_if  in_ch ();
	bms_out_if out_ch ();

	bunch_mean_and_std_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	// Predictor state: per-coordinate running totals of the current bunch.
	logic signed [bms_pkg::SumWidth-1:0] acc_sum [bms_pkg::NCoord];
	logic [bms_pkg::SqWidth-1:0]         acc_sq  [bms_pkg::NCoord];
	int unsigned                         acc_count;

	bms_pkg::out_item_t stats_queue [$];
	bms_pkg::out_item_t last_pred;

	int mismatches;
	int results_seen;
	int items_sent;
	int bunches_sent;
	int send_idle_pct;
	int recv_stall_pct;
	bit timed_out;

	function automatic logic [63:0] root_floor(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic signed [63:0] div_floor(input logic signed [63:0] a,
			input logic signed [63:0] n);
		logic signed [63:0] q;
		q = a / n;
		if ((a % n) != 0 && a < 0)
			q = q - 1;
		return q;
	endfunction

	// Clear the running totals, as the block does after a last particle.
	task automatic clear_totals();
		for (int i = 0; i < bms_pkg::NCoord; i++) begin
			acc_sum[i] = 0;
			acc_sq[i]  = 0;
		end
		acc_count = 0;
	endtask

	// Accumulate one particle; on last, queue the bunch statistics.
	task automatic predict_bunch_stats(input bms_pkg::in_item_t it);
		bms_pkg::coord_t c [bms_pkg::NCoord];
		logic signed [63:0] cc;
		logic signed [63:0] n;
		logic signed [63:0] mean;
		logic signed [63:0] rad;
		logic [63:0] sd;
		bms_pkg::out_item_t r;
		c[0] = it.pos_x;
		c[1] = it.angle_x;
		c[2] = it.energy_dev;
		c[3] = it.long_pos;
		if (acc_count < bms_pkg::MaxParticles) begin
			for (int i = 0; i < bms_pkg::NCoord; i++) begin
				cc = c[i];
				acc_sum[i] = acc_sum[i] + cc;
				acc_sq[i]  = acc_sq[i] + 64'(cc * cc);
			end
			acc_count++;
		end
		if (!it.last)
			return;
		r = '0;
		n = acc_count;
		for (int i = 0; i < bms_pkg::NCoord; i++) begin
			if (i > 0 && !it.full_stats)
				break;
			mean = div_floor(64'(acc_sum[i]), n);
			case (i)
				0: r.mean_x      = bms_pkg::coord_t'(mean);
				1: r.mean_angle  = bms_pkg::coord_t'(mean);
				2: r.mean_energy = bms_pkg::coord_t'(mean);
				default: r.mean_long = bms_pkg::coord_t'(mean);
			endcase
			if (!it.full_stats)
				break;
			rad = $signed(acc_sq[i] / 64'(acc_count)) - mean * mean;
			if (rad < 0)
				rad = 0;
			sd = root_floor(rad);
			if (sd > 64'((1 << bms_pkg::StdWidth) - 1))
				sd = (1 << bms_pkg::StdWidth) - 1;
			case (i)
				0: r.std_x      = sd[bms_pkg::StdWidth-1:0];
				1: r.std_angle  = sd[bms_pkg::StdWidth-1:0];
				2: r.std_energy = sd[bms_pkg::StdWidth-1:0];
				default: r.std_long = sd[bms_pkg::StdWidth-1:0];
			endcase
		end
		r.stats_full = it.full_stats;
		last_pred = r;
		stats_queue.insert(stats_queue.size(), r);
		clear_totals();
	endtask

	// Clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#100_000_000;
		timed_out = 1'b1;
		$display("Timeout with %0d results outstanding", stats_queue.size());
		$display("Regression FAIL");
		$finish;
	end

	// Receiver: stall at random, check each accepted result transaction.
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		bms_pkg::out_item_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_seen++;
			if (stats_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result %h", out_ch.data);
			end else begin
				want = stats_queue.pop_front();
				if (out_ch.data !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Mismatch on result %0d", results_seen);
						$display("  mean exp %0d %0d %0d %0d got %0d %0d %0d %0d",
							want.mean_x, want.mean_angle, want.mean_energy,
							want.mean_long, out_ch.data.mean_x,
							out_ch.data.mean_angle, out_ch.data.mean_energy,
							out_ch.data.mean_long);
						$display("  std exp %0d %0d %0d %0d full %0b", want.std_x,
							want.std_angle, want.std_energy, want.std_long,
							want.stats_full);
						$display("  std got %0d %0d %0d %0d full %0b",
							out_ch.data.std_x, out_ch.data.std_angle,
							out_ch.data.std_energy, out_ch.data.std_long,
							out_ch.data.stats_full);
					end
				end
			end
		end
	end

	// Hold one transaction on the input channel until it is accepted.
	task automatic send_particle(input bms_pkg::in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= it;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		predict_bunch_stats(it);
		items_sent++;
		if (it.last)
			bunches_sent++;
		@(negedge clk);
	endtask

	function automatic bms_pkg::coord_t rand_coord(input int mode);
		case (mode)
			0: return bms_pkg::coord_t'($urandom);
			1: return bms_pkg::coord_t'($urandom_range(63)) - bms_pkg::coord_t'(32);
			2: return {1'b0, {(bms_pkg::CoordWidth-1){1'b1}}} -
				bms_pkg::coord_t'($urandom_range(7));
			default: return {1'b1, {(bms_pkg::CoordWidth-1){1'b0}}} +
				bms_pkg::coord_t'($urandom_range(7));
		endcase
	endfunction

	// Send a whole bunch of the given size with random content.
	task automatic send_bunch(input int size, input bit full);
		bms_pkg::in_item_t it;
		int mode;
		mode = $urandom_range(3);
		for (int k = 0; k < size; k++) begin
			if ($urandom_range(3) == 0)
				mode = $urandom_range(3);
			it.pos_x      = rand_coord(mode);
			it.angle_x    = rand_coord(mode);
			it.energy_dev = rand_coord(mode);
			it.long_pos   = rand_coord(mode);
			it.full_stats = (k == size - 1) ? full : 1'($urandom);
			it.last       = (k == size - 1);
			send_particle(it);
		end
	endtask

	// Directed rows: particle, whether an expected result is typed in, result.
	localparam bms_pkg::coord_t CMAX = {1'b0, {(bms_pkg::CoordWidth-1){1'b1}}};
	localparam bms_pkg::coord_t CMIN = {1'b1, {(bms_pkg::CoordWidth-1){1'b0}}};
	localparam bms_pkg::coord_t CZ   = '0;
	localparam bms_pkg::coord_t CM1  = '1;

	typedef struct packed {
		bms_pkg::in_item_t  it;
		logic               chk;
		bms_pkg::out_item_t want;
	} dir_row_t;

	function automatic bms_pkg::in_item_t part(input bms_pkg::coord_t a,
			input bms_pkg::coord_t b, input bms_pkg::coord_t c,
			input bms_pkg::coord_t d, input logic f, input logic l);
		bms_pkg::in_item_t p;
		p.pos_x      = a;
		p.angle_x    = b;
		p.energy_dev = c;
		p.long_pos   = d;
		p.full_stats = f;
		p.last       = l;
		return p;
	endfunction

	// Every mean equal, no spread, full statistics.
	function automatic bms_pkg::out_item_t flat(input bms_pkg::coord_t m);
		bms_pkg::out_item_t r;
		r = '0;
		r.mean_x      = m;
		r.mean_angle  = m;
		r.mean_energy = m;
		r.mean_long   = m;
		r.stats_full  = 1'b1;
		return r;
	endfunction

	// First mean only, full statistics off.
	function automatic bms_pkg::out_item_t first_mean(input bms_pkg::coord_t m);
		bms_pkg::out_item_t r;
		r = '0;
		r.mean_x = m;
		return r;
	endfunction

	dir_row_t directed [15] = '{
		'{part(CZ, CZ, CZ, CZ, 1'b1, 1'b1), 1'b1, flat(CZ)},
		'{part(CMAX, CMAX, CMAX, CMAX, 1'b0, 1'b0), 1'b0, '0},
		'{part(CMAX, CMAX, CMAX, CMAX, 1'b1, 1'b1), 1'b1, flat(CMAX)},
		'{part(CMIN, CMIN, CMIN, CMIN, 1'b1, 1'b1), 1'b1, flat(CMIN)},
		'{part(CMIN, CMAX, CMIN, CMAX, 1'b1, 1'b0), 1'b0, '0},
		'{part(CMAX, CMIN, CMAX, CMIN, 1'b1, 1'b1), 1'b0, '0},
		'{part(CM1, CM1, CM1, CM1, 1'b0, 1'b0), 1'b0, '0},
		'{part(CZ, CZ, CZ, CZ, 1'b0, 1'b1), 1'b1, first_mean(CM1)},
		'{part(CM1, bms_pkg::coord_t'(1), bms_pkg::coord_t'(-3),
			bms_pkg::coord_t'(5), 1'b1, 1'b0), 1'b0, '0},
		'{part(CZ, CZ, bms_pkg::coord_t'(-2), CZ, 1'b1, 1'b0), 1'b0, '0},
		'{part(CZ, bms_pkg::coord_t'(2), CZ, bms_pkg::coord_t'(1), 1'b1, 1'b1),
			1'b0, '0},
		'{part(CMIN, bms_pkg::coord_t'(7), bms_pkg::coord_t'(-7), CZ, 1'b0, 1'b1),
			1'b1, first_mean(CMIN)},
		'{part(CMAX, CMIN, CZ, CZ, 1'b1, 1'b0), 1'b0, '0},
		'{part(CMIN, CMAX, CZ, CZ, 1'b0, 1'b0), 1'b0, '0},
		'{part(bms_pkg::coord_t'(1), bms_pkg::coord_t'(1), bms_pkg::coord_t'(1),
			bms_pkg::coord_t'(1), 1'b1, 1'b1), 1'b0, '0}
	};

	initial begin
		mismatches = 0;
		results_seen = 0;
		items_sent = 0;
		bunches_sent = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		timed_out = 1'b0;
		last_pred = '0;
		in_ch.valid = 1'b0;
		in_ch.data  = '0;
		clear_totals();
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: rows with a typed result also check the predictor.
		foreach (directed[i]) begin
			send_particle(directed[i].it);
			if (directed[i].chk && last_pred !== directed[i].want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Directed row %0d: exp %h got %h", i,
						directed[i].want, last_pred);
			end
		end

		// Random part through four idling phases.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 83; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 83; end
				default: begin send_idle_pct = 10; recv_stall_pct = 10; end
			endcase
			for (int b = 0; b < 17; b++)
				send_bunch($urandom_range(1, 24), $urandom_range(3) != 0);
			// Pause until the block has handed out everything pending.
			in_ch.valid <= 1'b0;
			while (stats_queue.size() != 0)
				@(negedge clk);
		end

		in_ch.valid <= 1'b0;
		while (stats_queue.size() != 0)
			@(negedge clk);
		repeat (700) @(negedge clk);

		$display("Sent %0d particles in %0d bunches, checked %0d results",
			items_sent, bunches_sent, results_seen);
		$display("Directed extremes, then random bunches under four idling mixes");
		if (mismatches == 0 && !timed_out) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
